// ----- rtl/core/spcd_pkg.sv -----
`default_nettype none
package spcd_pkg;

	localparam int RING_DEPTH_DEF = 10;
	localparam int VAL_W = 22;
	localparam int SPW_MAX = 64;
	localparam int QUOT_MSB = 17;
	localparam int CHUNK_W = 18;

	localparam logic [6:0] SPW_RESET = 7'd6;
	localparam logic [15:0] THR_RESET = 16'd10;
	localparam logic [15:0] MPS_RESET = 16'd30;

	localparam logic [1:0] CFG_SPW = 2'd0;
	localparam logic [1:0] CFG_THR = 2'd1;
	localparam logic [1:0] CFG_MPS = 2'd2;

	typedef struct packed {
		logic [VAL_W-1:0] ps;
		logic [VAL_W-1:0] pf;
		logic [6:0]       spw;
		logic [31:0]      cnt;
		logic [47:0]      sbase;
		logic [47:0]      fbase;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MEAN,
		ST_WRITE,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_NBR_RD,
		ST_NBR_EV,
		ST_MUL,
		ST_TEST,
		ST_WMUL,
		ST_WDIV,
		ST_EMIT
	} bk_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/spcd_in_if.sv -----
`default_nettype none
interface spcd_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] forward_sample;
	logic [15:0] side_sample;

	modport source(output valid, forward_sample, side_sample, input ready);
	modport sink(input valid, forward_sample, side_sample, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/spcd_out_if.sv -----
`default_nettype none
interface spcd_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        smoothed_side;
	logic [15:0]        smoothed_forward;
	logic               peak_found;
	logic [15:0]        peak_height;
	logic [31:0]        peak_time;
	logic signed [15:0] width_estimate;
	logic               is_cell;
	logic [31:0]        cell_interval;
	logic [31:0]        cell_total;

	modport source(output valid, smoothed_side, smoothed_forward, peak_found, peak_height,
		peak_time, width_estimate, is_cell, cell_interval, cell_total, input ready);
	modport sink(input valid, smoothed_side, smoothed_forward, peak_found, peak_height,
		peak_time, width_estimate, is_cell, cell_interval, cell_total, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/scatter_peak_cell_detector_core.sv -----
// Non-final samples transfer one per cycle while the window queue has room.
// A completed window passes in the back end through the mean divider, the ring write,
// a scan that reads each ring entry, the neighbor reads when the peak sits mid-ring,
// the products and the peak test, and, for a found peak, the width multiply and divider.
// Two completed windows can wait in the queue while one is processed.
// arst_n clears the control state, the ring valid bits and the configuration registers.
`default_nettype none
module scatter_peak_cell_detector_core #(
	parameter int RING_DEPTH = spcd_pkg::RING_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	spcd_in_if.sink          sample_in,
	spcd_out_if.source       result_out,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [6:0]     spw_q;
	logic [15:0]    thr_q, mps_q;
	logic           push, q_full, pop, head_valid;
	spcd_pkg::job_t push_job, head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spw_q <= spcd_pkg::SPW_RESET;
			thr_q <= spcd_pkg::THR_RESET;
			mps_q <= spcd_pkg::MPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spcd_pkg::CFG_SPW: spw_q <= cfg_data[6:0];
				spcd_pkg::CFG_THR: thr_q <= cfg_data;
				spcd_pkg::CFG_MPS: mps_q <= cfg_data;
				default: ;
			endcase
		end
	end

	spcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_in(sample_in),
		.spw      (spw_q),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	spcd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head_job  (head_job)
	);

	spcd_back #(
		.RING_DEPTH(RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (head_valid),
		.job       (head_job),
		.pop       (pop),
		.thr       (thr_q),
		.mps       (mps_q),
		.result_out(result_out)
	);

endmodule
`default_nettype wire

// ----- rtl/core/spcd_queue.sv -----
`default_nettype none
module spcd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire spcd_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               head_valid,
	output spcd_pkg::job_t     head_job
);

	spcd_pkg::job_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_job   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/spcd_front.sv -----
`default_nettype none
module spcd_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	spcd_in_if.sink             sample_in,
	input  wire logic [6:0]     spw,
	input  wire logic           q_full,
	output logic                push,
	output spcd_pkg::job_t      push_job
);

	localparam int VW = spcd_pkg::VAL_W;

	logic [VW-1:0] ps_q, pf_q;
	logic [6:0]    n_q;
	logic [31:0]   cnt_q;
	logic [47:0]   sbase_q, fbase_q;

	logic          acc;
	logic [6:0]    spw_eff, n_nx;
	logic [VW-1:0] ps_nx, pf_nx;
	logic [31:0]   cnt_nx;
	logic [47:0]   sbase_nx, fbase_nx;
	logic          done;

	assign sample_in.ready = !q_full;
	assign acc = sample_in.valid && sample_in.ready;

	always_comb begin
		if (spw == 7'd0) spw_eff = 7'd1;
		else if (spw > 7'(spcd_pkg::SPW_MAX)) spw_eff = 7'(spcd_pkg::SPW_MAX);
		else spw_eff = spw;
		ps_nx    = ps_q + VW'(sample_in.side_sample);
		pf_nx    = pf_q + VW'(sample_in.forward_sample);
		n_nx     = n_q + 7'd1;
		cnt_nx   = cnt_q + 32'd1;
		sbase_nx = sbase_q + 48'(sample_in.side_sample);
		fbase_nx = fbase_q + 48'(sample_in.forward_sample);
		done     = (n_nx >= spw_eff);
	end

	assign push           = acc && done;
	assign push_job.ps    = ps_nx;
	assign push_job.pf    = pf_nx;
	assign push_job.spw   = spw_eff;
	assign push_job.cnt   = cnt_nx;
	assign push_job.sbase = sbase_nx;
	assign push_job.fbase = fbase_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q    <= '0;
			pf_q    <= '0;
			n_q     <= '0;
			cnt_q   <= '0;
			sbase_q <= '0;
			fbase_q <= '0;
		end else if (acc) begin
			cnt_q   <= cnt_nx;
			sbase_q <= sbase_nx;
			fbase_q <= fbase_nx;
			if (done) begin
				ps_q <= '0;
				pf_q <= '0;
				n_q  <= '0;
			end else begin
				ps_q <= ps_nx;
				pf_q <= pf_nx;
				n_q  <= n_nx;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/spcd_back.sv -----
`default_nettype none
module spcd_back #(
	parameter int RING_DEPTH = spcd_pkg::RING_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	input  wire spcd_pkg::job_t job,
	output logic                pop,
	input  wire logic [15:0]    thr,
	input  wire logic [15:0]    mps,
	spcd_out_if.source          result_out
);

	localparam int VW = spcd_pkg::VAL_W;
	localparam int SW = $clog2(RING_DEPTH);
	localparam int RW = 2 * VW + 32;
	localparam int QM = spcd_pkg::QUOT_MSB;
	localparam int CW = spcd_pkg::CHUNK_W;

	function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] x);
		wrap_inc = (x == SW'(RING_DEPTH - 1)) ? '0 : x + 1'b1;
	endfunction

	spcd_pkg::bk_state_t state_q, state_d;

	spcd_pkg::job_t  job_q;
	logic [VW-1:0]   ds_q, df_q, qs_q, qf_q;
	logic [6:0]      rs_q, rf_q;
	logic [4:0]      dcnt_q;

	logic [RW-1:0]   ring_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] ring_vld_q;
	logic [RW-1:0]   rd_q;
	logic            rd_vld_q;
	logic [SW-1:0]   raddr;

	logic [SW-1:0]   wslot_q, j_q, k_q, pslot_q, nj_q;
	logic [VW-1:0]   pmax_q, fmax_q;
	logic [31:0]     ptime_q;
	logic            mid_q;
	logic [1:0]      n_q;
	logic [33:0]     xs_q;
	logic [23:0]     ys_q;

	logic [53:0]     pc_q, ptc_q, fc_q;
	logic [47:0]     tc_q;
	logic [34:0]     b_q;
	logic [24:0]     d_q;

	logic [53:0]     ma_q;
	logic [33:0]     mb_q;
	logic            neg_q;
	logic [55:0]     dv_q;
	logic [1:0]      c_q;
	logic [87:0]     rem_q;
	logic [72:0]     dsh_q;
	logic [4:0]      i_q;
	logic [QM-1:0]   q_q;
	logic            sat_q;

	logic [31:0]     last_pk_q, last_cell_q, cells_q;
	logic            found_q, cell_q;
	logic [31:0]     interval_q;
	logic            ovalid_q;

	logic [VW-1:0]   rd_side, rd_fwd;
	logic [31:0]     rd_time;
	logic            upd, mid_n;
	logic [SW-1:0]   pslot_n;
	logic [7:0]      rs_n, rf_n;
	logic            ges, gef;
	logic            peak, cell_hit;
	logic [53:0]     dev;
	logic [54:0]     a_s;
	logic [53:0]     ma_n;
	logic [33:0]     mb_n;
	logic [23:0]     md_n;
	logic [51:0]     cprod;
	logic            dge;
	logic            free;
	logic signed [15:0] wv;

	assign rd_side = rd_vld_q ? rd_q[RW-1 -: VW] : '0;
	assign rd_fwd  = rd_vld_q ? rd_q[31+VW -: VW] : '0;
	assign rd_time = rd_vld_q ? rd_q[31:0] : '0;
	assign raddr   = (state_q == spcd_pkg::ST_NBR_RD) ? nj_q : j_q;
	assign free    = !ovalid_q || result_out.ready;
	assign pop     = (state_q == spcd_pkg::ST_IDLE) && job_valid;

	always_comb begin
		rs_n    = {rs_q, ds_q[VW-1]};
		rf_n    = {rf_q, df_q[VW-1]};
		ges     = rs_n >= {1'b0, job_q.spw};
		gef     = rf_n >= {1'b0, job_q.spw};
		upd     = rd_side > pmax_q;
		mid_n   = upd ? (k_q == SW'(RING_DEPTH / 2)) : mid_q;
		pslot_n = upd ? j_q : pslot_q;
		peak    = (pmax_q > VW'(thr)) && (ptc_q > 54'(job_q.sbase)) && mid_q &&
			((ptime_q - last_pk_q) > 32'(mps));
		dev     = (fc_q > 54'(job_q.fbase)) ? fc_q - 54'(job_q.fbase)
			: 54'(job_q.fbase) - fc_q;
		cell_hit = peak && (dev > 54'(tc_q));
		a_s     = {7'd0, job_q.sbase} - {1'b0, pc_q};
		ma_n    = a_s[54] ? 54'(-a_s) : a_s[53:0];
		mb_n    = b_q[34] ? 34'(-b_q) : b_q[33:0];
		md_n    = d_q[24] ? 24'(-d_q) : d_q[23:0];
		cprod   = ma_q[c_q*CW +: CW] * mb_q;
		dge     = rem_q >= 88'(dsh_q);
		if (!found_q || dv_q == '0) wv = '0;
		else if (sat_q) wv = neg_q ? 16'sh8000 : 16'sh7FFF;
		else if (neg_q) wv = (q_q > QM'(32768)) ? 16'sh8000 : 16'(QM'(0) - q_q);
		else wv = (q_q > QM'(32767)) ? 16'sh7FFF : 16'(q_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= spcd_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spcd_pkg::ST_IDLE: if (job_valid) state_d = spcd_pkg::ST_MEAN;
			spcd_pkg::ST_MEAN: if (dcnt_q == 5'd0) state_d = spcd_pkg::ST_WRITE;
			spcd_pkg::ST_WRITE: state_d = spcd_pkg::ST_SCAN_RD;
			spcd_pkg::ST_SCAN_RD: state_d = spcd_pkg::ST_SCAN_EV;
			spcd_pkg::ST_SCAN_EV: begin
				if (k_q == SW'(RING_DEPTH - 1))
					state_d = mid_n ? spcd_pkg::ST_NBR_RD : spcd_pkg::ST_MUL;
				else
					state_d = spcd_pkg::ST_SCAN_RD;
			end
			spcd_pkg::ST_NBR_RD: state_d = spcd_pkg::ST_NBR_EV;
			spcd_pkg::ST_NBR_EV: state_d = (n_q == 2'd2) ? spcd_pkg::ST_MUL : spcd_pkg::ST_NBR_RD;
			spcd_pkg::ST_MUL: state_d = spcd_pkg::ST_TEST;
			spcd_pkg::ST_TEST: state_d = peak ? spcd_pkg::ST_WMUL : spcd_pkg::ST_EMIT;
			spcd_pkg::ST_WMUL: if (c_q == 2'd2) state_d = spcd_pkg::ST_WDIV;
			spcd_pkg::ST_WDIV: begin
				if ((i_q == 5'(QM) && dge) || i_q == 5'd0) state_d = spcd_pkg::ST_EMIT;
			end
			spcd_pkg::ST_EMIT: if (free) state_d = spcd_pkg::ST_IDLE;
			default: state_d = spcd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == spcd_pkg::ST_WRITE) ring_mem[wslot_q] <= {qs_q, qf_q, job_q.cnt};
		rd_q <= ring_mem[raddr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			spcd_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_q  <= job;
					ds_q   <= job.ps;
					df_q   <= job.pf;
					rs_q   <= '0;
					rf_q   <= '0;
					qs_q   <= '0;
					qf_q   <= '0;
					dcnt_q <= 5'(VW - 1);
				end
			end
			spcd_pkg::ST_MEAN: begin
				ds_q   <= ds_q << 1;
				df_q   <= df_q << 1;
				qs_q   <= {qs_q[VW-2:0], ges};
				qf_q   <= {qf_q[VW-2:0], gef};
				rs_q   <= ges ? 7'(rs_n - {1'b0, job_q.spw}) : rs_n[6:0];
				rf_q   <= gef ? 7'(rf_n - {1'b0, job_q.spw}) : rf_n[6:0];
				dcnt_q <= dcnt_q - 5'd1;
			end
			spcd_pkg::ST_WRITE: begin
				j_q     <= wslot_q;
				k_q     <= '0;
				pmax_q  <= '0;
				fmax_q  <= '0;
				ptime_q <= '0;
				mid_q   <= 1'b0;
				pslot_q <= wslot_q;
			end
			spcd_pkg::ST_SCAN_RD: ;
			spcd_pkg::ST_SCAN_EV: begin
				if (upd) begin
					pmax_q  <= rd_side;
					ptime_q <= rd_time;
				end
				if (rd_fwd > fmax_q) fmax_q <= rd_fwd;
				mid_q   <= mid_n;
				pslot_q <= pslot_n;
				j_q     <= wrap_inc(j_q);
				k_q     <= k_q + 1'b1;
				nj_q    <= wrap_inc(pslot_n);
				n_q     <= '0;
				xs_q    <= '0;
				ys_q    <= '0;
			end
			spcd_pkg::ST_NBR_RD: ;
			spcd_pkg::ST_NBR_EV: begin
				xs_q <= xs_q + 34'(rd_time);
				ys_q <= ys_q + 24'(rd_side);
				nj_q <= wrap_inc(nj_q);
				n_q  <= n_q + 2'd1;
			end
			spcd_pkg::ST_MUL: begin
				pc_q  <= pmax_q * job_q.cnt;
				ptc_q <= (pmax_q - VW'(thr)) * job_q.cnt;
				fc_q  <= fmax_q * job_q.cnt;
				tc_q  <= thr * job_q.cnt;
				b_q   <= {1'b0, 34'(ptime_q) * 34'd3} - {1'b0, xs_q};
				d_q   <= {1'b0, 24'(pmax_q) * 24'd3} - {1'b0, ys_q};
			end
			spcd_pkg::ST_TEST: begin
				ma_q       <= ma_n;
				mb_q       <= mb_n;
				neg_q      <= a_s[54] ^ b_q[34] ^ d_q[24];
				dv_q       <= job_q.cnt * md_n;
				c_q        <= '0;
				rem_q      <= '0;
				i_q        <= 5'(QM);
				q_q        <= '0;
				sat_q      <= 1'b0;
				found_q    <= peak;
				cell_q     <= cell_hit;
				interval_q <= cell_hit ? ptime_q - last_cell_q : '0;
				dsh_q      <= '0;
			end
			spcd_pkg::ST_WMUL: begin
				rem_q <= rem_q + (88'(cprod) << (7'(c_q) * 7'(CW)));
				c_q   <= c_q + 2'd1;
				dsh_q <= {dv_q, QM'(0)};
			end
			spcd_pkg::ST_WDIV: begin
				if (dge) rem_q <= rem_q - 88'(dsh_q);
				if (i_q == 5'(QM)) sat_q <= dge;
				else q_q <= {q_q[QM-2:0], dge};
				dsh_q <= dsh_q >> 1;
				i_q   <= i_q - 5'd1;
			end
			spcd_pkg::ST_EMIT: begin
				if (free) begin
					result_out.smoothed_side    <= qs_q[15:0];
					result_out.smoothed_forward <= qf_q[15:0];
					result_out.peak_found       <= found_q;
					result_out.peak_height      <= found_q ? pmax_q[15:0] : '0;
					result_out.peak_time        <= found_q ? ptime_q : '0;
					result_out.width_estimate   <= wv;
					result_out.is_cell          <= cell_q;
					result_out.cell_interval    <= interval_q;
					result_out.cell_total       <= cells_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wslot_q     <= '0;
			ring_vld_q  <= '0;
			rd_vld_q    <= 1'b0;
			last_pk_q   <= '0;
			last_cell_q <= '0;
			cells_q     <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			rd_vld_q <= ring_vld_q[raddr];
			if (state_q == spcd_pkg::ST_WRITE) begin
				ring_vld_q[wslot_q] <= 1'b1;
				wslot_q             <= wrap_inc(wslot_q);
			end
			if (state_q == spcd_pkg::ST_TEST && peak) last_pk_q <= ptime_q;
			if (state_q == spcd_pkg::ST_TEST && cell_hit) begin
				last_cell_q <= ptime_q;
				if (cells_q != '1) cells_q <= cells_q + 32'd1;
			end
			if (state_q == spcd_pkg::ST_EMIT && free) ovalid_q <= 1'b1;
			else if (result_out.ready) ovalid_q <= 1'b0;
		end
	end

	assign result_out.valid = ovalid_q;

	a_wslot_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(wslot_q) < RING_DEPTH)
		else $error("ring write slot out of range");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spcd_pkg::ST_WRITE |=> ring_vld_q[$past(wslot_q)])
		else $error("written ring entry not marked valid");

	a_cells_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cells_q >= $past(cells_q))
		else $error("cell count went backwards");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spcd_pkg::ST_EMIT && free) |=> result_out.valid)
		else $error("emitted result not presented");

endmodule
`default_nettype wire
